/* rtl/ialu_pkg.sv */
package ialu_pkg;

  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_ADDL   = 5'd0;
  localparam cmd_t CMD_ADDL_V = 5'd1;
  localparam cmd_t CMD_ADDQ   = 5'd2;
  localparam cmd_t CMD_ADDQ_V = 5'd3;
  localparam cmd_t CMD_S4ADDL = 5'd4;
  localparam cmd_t CMD_S8ADDL = 5'd5;
  localparam cmd_t CMD_S4ADDQ = 5'd6;
  localparam cmd_t CMD_S8ADDQ = 5'd7;
  localparam cmd_t CMD_CMPEQ  = 5'd8;
  localparam cmd_t CMD_CMPLE  = 5'd9;
  localparam cmd_t CMD_CMPLT  = 5'd10;
  localparam cmd_t CMD_CMPULE = 5'd11;
  localparam cmd_t CMD_CTLZ   = 5'd12;
  localparam cmd_t CMD_CTTZ   = 5'd13;
  localparam cmd_t CMD_MULL   = 5'd14;
  localparam cmd_t CMD_MULL_V = 5'd15;
  localparam cmd_t CMD_MULQ   = 5'd16;
  localparam cmd_t CMD_MULQ_V = 5'd17;
  localparam cmd_t CMD_UMULH  = 5'd18;
  localparam cmd_t CMD_SUBL   = 5'd19;
  localparam cmd_t CMD_SUBL_V = 5'd20;
  localparam cmd_t CMD_SUBQ   = 5'd21;
  localparam cmd_t CMD_SUBQ_V = 5'd22;
  localparam cmd_t CMD_S4SUBL = 5'd23;
  localparam cmd_t CMD_S8SUBL = 5'd24;
  localparam cmd_t CMD_S4SUBQ = 5'd25;
  localparam cmd_t CMD_S8SUBQ = 5'd26;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        use_literal;
    logic [7:0]  literal_value;
  } ialu_in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        overflow_trap;
  } ialu_out_t;

  // Per-stage load enables for the multiplier pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } ialu_adv_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

/* rtl/ialu_alu.sv */
module ialu_alu
  import ialu_pkg::*;
(
  input  cmd_t        cmd,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output ialu_out_t   res
);

  logic [63:0] scaled;
  logic [63:0] sum;
  logic [63:0] diff;
  logic [63:0] b_rev;
  logic [6:0]  lz;
  logic [6:0]  tz;

  // Binary search in six halving steps; an all-zero word counts as 64.
  function automatic logic [6:0] lead_zeros(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  n;
    x = v;
    n = '0;
    if (x[63:32] == '0) begin
      n[5] = 1'b1;
      x = x << 32;
    end
    if (x[63:48] == '0) begin
      n[4] = 1'b1;
      x = x << 16;
    end
    if (x[63:56] == '0) begin
      n[3] = 1'b1;
      x = x << 8;
    end
    if (x[63:60] == '0) begin
      n[2] = 1'b1;
      x = x << 4;
    end
    if (x[63:62] == '0) begin
      n[1] = 1'b1;
      x = x << 2;
    end
    if (!x[63]) begin
      n[0] = 1'b1;
    end
    if (v == '0) begin
      return 7'd64;
    end
    return {1'b0, n};
  endfunction

  always_comb begin
    if (cmd inside {CMD_S4ADDL, CMD_S4ADDQ, CMD_S4SUBL, CMD_S4SUBQ}) begin
      scaled = op_a << 2;
    end else if (cmd inside {CMD_S8ADDL, CMD_S8ADDQ, CMD_S8SUBL, CMD_S8SUBQ}) begin
      scaled = op_a << 3;
    end else begin
      scaled = op_a;
    end
  end

  assign sum  = scaled + op_b;
  assign diff = scaled - op_b;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      b_rev[i] = op_b[63 - i];
    end
  end

  assign lz = lead_zeros(op_b);
  assign tz = lead_zeros(b_rev);

  always_comb begin
    res = '0;
    case (cmd)
      CMD_ADDL, CMD_ADDL_V, CMD_S4ADDL, CMD_S8ADDL: begin
        res.result        = sext32(sum[31:0]);
        res.overflow_trap = (cmd == CMD_ADDL_V) &
                            (scaled[31] ^ sum[31]) & (op_b[31] ^ sum[31]);
      end
      CMD_ADDQ, CMD_ADDQ_V, CMD_S4ADDQ, CMD_S8ADDQ: begin
        res.result        = sum;
        res.overflow_trap = (cmd == CMD_ADDQ_V) &
                            (scaled[63] ^ sum[63]) & (op_b[63] ^ sum[63]);
      end
      CMD_SUBL, CMD_SUBL_V, CMD_S4SUBL, CMD_S8SUBL: begin
        res.result        = sext32(diff[31:0]);
        res.overflow_trap = (cmd == CMD_SUBL_V) &
                            (scaled[31] ^ op_b[31]) & (scaled[31] ^ diff[31]);
      end
      CMD_SUBQ, CMD_SUBQ_V, CMD_S4SUBQ, CMD_S8SUBQ: begin
        res.result        = diff;
        res.overflow_trap = (cmd == CMD_SUBQ_V) &
                            (scaled[63] ^ op_b[63]) & (scaled[63] ^ diff[63]);
      end
      CMD_CMPEQ:  res.result = {63'd0, op_a == op_b};
      CMD_CMPLE:  res.result = {63'd0, $signed(op_a) <= $signed(op_b)};
      CMD_CMPLT:  res.result = {63'd0, $signed(op_a) < $signed(op_b)};
      CMD_CMPULE: res.result = {63'd0, op_a <= op_b};
      CMD_CTLZ:   res.result = {57'd0, lz};
      CMD_CTTZ:   res.result = {57'd0, tz};
      default:    res = '0;
    endcase
  end

endmodule

/* rtl/ialu_mul.sv */
module ialu_mul
  import ialu_pkg::*;
(
  input  logic        clk,
  input  ialu_adv_t   adv,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic [63:0] prod_lo,
  output logic [63:0] prod_hi,
  output logic [63:0] hi_signed,
  output logic        mull_ovf
);

  // Stage 1: four 32x32 partial products, the signed longword product and
  // the correction that turns the unsigned high half into the signed one.
  logic [63:0]        ll_r, lh_r, hl_r, hh_r, corr1_r;
  logic signed [63:0] mls_r;
  logic [63:0]        ll_nxt, lh_nxt, hl_nxt, hh_nxt, corr1_nxt;
  logic signed [63:0] mls_nxt;

  assign ll_nxt    = op_a[31:0] * op_b[31:0];
  assign lh_nxt    = op_a[31:0] * op_b[63:32];
  assign hl_nxt    = op_a[63:32] * op_b[31:0];
  assign hh_nxt    = op_a[63:32] * op_b[63:32];
  assign mls_nxt   = $signed(op_a[31:0]) * $signed(op_b[31:0]);
  assign corr1_nxt = (op_a[63] ? op_b : 64'd0) + (op_b[63] ? op_a : 64'd0);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ll_r    <= ll_nxt;
      lh_r    <= lh_nxt;
      hl_r    <= hl_nxt;
      hh_r    <= hh_nxt;
      mls_r   <= mls_nxt;
      corr1_r <= corr1_nxt;
    end
  end

  // Stage 2: middle column sum and the high column sum without its carry.
  logic [33:0] mid_r, mid_nxt;
  logic [63:0] hsum_r, hsum_nxt, corr2_r;
  logic [31:0] lo32_r;
  logic        ovf2_r, ovf2_nxt;

  assign mid_nxt  = 34'(ll_r[63:32]) + 34'(lh_r[31:0]) + 34'(hl_r[31:0]);
  assign hsum_nxt = hh_r + 64'(lh_r[63:32]) + 64'(hl_r[63:32]);
  // The longword product overflows when bits 63..31 are not all equal.
  assign ovf2_nxt = !((mls_r[63:31] == '0) || (mls_r[63:31] == '1));

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      mid_r   <= mid_nxt;
      hsum_r  <= hsum_nxt;
      corr2_r <= corr1_r;
      lo32_r  <= ll_r[31:0];
      ovf2_r  <= ovf2_nxt;
    end
  end

  // Stage 3: final halves.
  logic [63:0] lo_r, hi_r, his_r;
  logic [63:0] lo_nxt, hi_nxt, his_nxt;
  logic        ovf3_r;

  assign lo_nxt  = {mid_r[31:0], lo32_r};
  assign hi_nxt  = hsum_r + 64'(mid_r[33:32]);
  assign his_nxt = hsum_r + 64'(mid_r[33:32]) - corr2_r;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      his_r  <= his_nxt;
      ovf3_r <= ovf2_r;
    end
  end

  assign prod_lo   = lo_r;
  assign prod_hi   = hi_r;
  assign hi_signed = his_r;
  assign mull_ovf  = ovf3_r;

endmodule

/* rtl/integer_alu_add_sub_mul_cmp.sv */
// Channel   Direction  Ports                         Payload
// input     in         in_valid, in_stall, in_data   ialu_in_t
// result    out        out_valid, out_stall, out_data ialu_out_t
//
// An instruction passes through the partial-product, column-sum and final-half stages,
// then the result register; a new one can be taken in every cycle while in_stall is low.
// The pipeline depth is set by the 64x64 multiplier, cut into partial products,
// column sums and final halves ahead of the result register.
// Reset clears the valid bits of all stages; the data registers are not reset.
// A stall holds only stages whose successor is full, so bubbles close up.
module integer_alu_add_sub_mul_cmp
  import ialu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ialu_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ialu_out_t out_data
);

  ialu_adv_t   adv;
  logic        adv4;
  logic        v1_r, v2_r, v3_r, out_valid_r;
  cmd_t        cmd1_r, cmd2_r, cmd3_r;
  logic [63:0] a1_r, b1_r;
  ialu_out_t   alu_res;
  ialu_out_t   alu2_r, alu3_r;
  ialu_out_t   out_data_r, out_data_nxt;
  logic [63:0] b_sel;
  logic [63:0] prod_lo, prod_hi, hi_signed;
  logic        mull_ovf;

  assign adv4   = !out_valid_r || !out_stall;
  assign adv.s3 = !v3_r || adv4;
  assign adv.s2 = !v2_r || adv.s3;
  assign adv.s1 = !v1_r || adv.s2;

  assign in_stall = !adv.s1;

  assign b_sel = in_data.use_literal ? {56'd0, in_data.literal_value}
                                     : in_data.operand_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1_r <= in_valid;
      end
      if (adv.s2) begin
        v2_r <= v1_r;
      end
      if (adv.s3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      cmd1_r <= in_data.command;
      a1_r   <= in_data.operand_a;
      b1_r   <= b_sel;
    end
    if (adv.s2) begin
      cmd2_r <= cmd1_r;
      alu2_r <= alu_res;
    end
    if (adv.s3) begin
      cmd3_r <= cmd2_r;
      alu3_r <= alu2_r;
    end
    if (adv4) begin
      out_data_r <= out_data_nxt;
    end
  end

  ialu_alu u_alu (
    .cmd  (cmd1_r),
    .op_a (a1_r),
    .op_b (b1_r),
    .res  (alu_res)
  );

  ialu_mul u_mul (
    .clk       (clk),
    .adv       (adv),
    .op_a      (in_data.operand_a),
    .op_b      (b_sel),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi),
    .hi_signed (hi_signed),
    .mull_ovf  (mull_ovf)
  );

  always_comb begin
    out_data_nxt = '0;
    case (cmd3_r)
      CMD_MULL, CMD_MULL_V: begin
        out_data_nxt.result        = sext32(prod_lo[31:0]);
        out_data_nxt.overflow_trap = (cmd3_r == CMD_MULL_V) & mull_ovf;
      end
      CMD_MULQ, CMD_MULQ_V: begin
        // The signed high half must match the sign of the low half.
        out_data_nxt.result        = prod_lo;
        out_data_nxt.overflow_trap = (cmd3_r == CMD_MULQ_V) &
                                     (hi_signed != {64{prod_lo[63]}});
      end
      CMD_UMULH: begin
        out_data_nxt.result = prod_hi;
      end
      default: out_data_nxt = alu3_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* test/tb_integer_alu_add_sub_mul_cmp.sv */
module tb_integer_alu_add_sub_mul_cmp;
  import ialu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ialu_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ialu_out_t out_data;

  ialu_in_t  instr_q[$];
  ialu_out_t writeback_q[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        idle_phase = 0;
  int        hold_left = 0;
  bit        held_once = 1'b0;

  integer_alu_add_sub_mul_cmp dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Expected writeback value and overflow flag for one instruction.
  function automatic ialu_out_t alu_writeback(ialu_in_t it);
    logic [63:0]  a, b, s, r, p;
    logic [127:0] wide;
    logic         t;
    int           n;
    ialu_out_t    res;
    a = it.operand_a;
    b = it.use_literal ? {56'd0, it.literal_value} : it.operand_b;
    r = '0;
    t = 1'b0;
    n = 0;
    case (it.command)
      CMD_S4ADDL, CMD_S4ADDQ, CMD_S4SUBL, CMD_S4SUBQ: s = a << 2;
      CMD_S8ADDL, CMD_S8ADDQ, CMD_S8SUBL, CMD_S8SUBQ: s = a << 3;
      default: s = a;
    endcase
    case (it.command)
      CMD_ADDL, CMD_ADDL_V, CMD_S4ADDL, CMD_S8ADDL: begin
        r = s + b;
        r = {{32{r[31]}}, r[31:0]};
        t = (it.command == CMD_ADDL_V) & (s[31] ^ r[31]) & (b[31] ^ r[31]);
      end
      CMD_ADDQ, CMD_ADDQ_V, CMD_S4ADDQ, CMD_S8ADDQ: begin
        r = s + b;
        t = (it.command == CMD_ADDQ_V) & (s[63] ^ r[63]) & (b[63] ^ r[63]);
      end
      CMD_SUBL, CMD_SUBL_V, CMD_S4SUBL, CMD_S8SUBL: begin
        r = s - b;
        r = {{32{r[31]}}, r[31:0]};
        t = (it.command == CMD_SUBL_V) & (s[31] ^ b[31]) & (s[31] ^ r[31]);
      end
      CMD_SUBQ, CMD_SUBQ_V, CMD_S4SUBQ, CMD_S8SUBQ: begin
        r = s - b;
        t = (it.command == CMD_SUBQ_V) & (s[63] ^ b[63]) & (s[63] ^ r[63]);
      end
      CMD_CMPEQ:  r = {63'd0, a == b};
      CMD_CMPLE:  r = {63'd0, $signed(a) <= $signed(b)};
      CMD_CMPLT:  r = {63'd0, $signed(a) < $signed(b)};
      CMD_CMPULE: r = {63'd0, a <= b};
      CMD_CTLZ: begin
        while (n < 64 && !b[63 - n]) n++;
        r = 64'(n);
      end
      CMD_CTTZ: begin
        while (n < 64 && !b[n]) n++;
        r = 64'(n);
      end
      CMD_MULL, CMD_MULL_V: begin
        p = {{32{a[31]}}, a[31:0]} * {{32{b[31]}}, b[31:0]};
        r = {{32{p[31]}}, p[31:0]};
        t = (it.command == CMD_MULL_V) & (p != r);
      end
      CMD_MULQ, CMD_MULQ_V: begin
        wide = {{64{a[63]}}, a} * {{64{b[63]}}, b};
        r = wide[63:0];
        t = (it.command == CMD_MULQ_V) & (wide[127:64] != {64{wide[63]}});
      end
      CMD_UMULH: begin
        wide = {64'd0, a} * {64'd0, b};
        r = wide[127:64];
      end
      default: r = '0;
    endcase
    res.result = r;
    res.overflow_trap = t;
    return res;
  endfunction

  // Idling is suppressed for part of every window so that back-to-back runs occur.
  function automatic bit idle_draw(int pct);
    return (cycle_count % 300 < 240) && ($urandom_range(99) < pct);
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {1'b1, 63'd0};
      3: return {1'b0, {63{1'b1}}};
      4: return {32'($urandom), ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000)};
      5: return 64'($urandom_range(16));
      6: return {{32{1'b1}}, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic queue_instr(cmd_t c, logic [63:0] a, logic [63:0] b, bit lit_sel,
                             logic [7:0] lit);
    ialu_in_t it;
    it.command = c;
    it.operand_a = a;
    it.operand_b = b;
    it.use_literal = lit_sel;
    it.literal_value = lit;
    instr_q.push_back(it);
  endtask

  task automatic queue_random(int count);
    ialu_in_t it;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) begin
        it.command = cmd_t'($urandom_range(CMD_S8SUBQ + 1, 2 ** $bits(cmd_t) - 1));
      end else begin
        it.command = cmd_t'($urandom_range(CMD_S8SUBQ));
      end
      it.operand_a = pick_operand();
      it.operand_b = pick_operand();
      it.use_literal = 1'($urandom_range(1));
      it.literal_value = 8'($urandom);
      instr_q.push_back(it);
    end
  endtask

  // Sender: a new instruction is offered once the previous one has transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) writeback_q.push_back(alu_writeback(in_data));
      if (instr_q.size() > 0 &&
          !idle_draw(idle_phase == 0 ? 38 : idle_phase == 1 ? 79 : 0)) begin
        in_data <= instr_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transfer and decides the stall for the next cycle.
  always @(posedge clk) begin
    ialu_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (writeback_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: result=%h overflow_trap=%b",
                   out_data.result, out_data.overflow_trap);
      end else begin
        want = writeback_q.pop_front();
        if (out_data.result !== want.result ||
            out_data.overflow_trap !== want.overflow_trap) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: result exp %h got %h, overflow_trap exp %b got %b",
                     want.result, out_data.result, want.overflow_trap,
                     out_data.overflow_trap);
        end
      end
    end
    if (idle_phase == 2 && !held_once) begin
      hold_left = HOLD_OFF_CYCLES;
      held_once = 1'b1;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_draw(idle_phase == 0 ? 79 : idle_phase == 1 ? 38 : 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Overflow boundaries, sign extremes, zero counts and full-width scaled operands.
    queue_instr(CMD_ADDL,   64'h7fff_ffff, 64'd1, 1'b0, 8'h00);
    queue_instr(CMD_ADDL_V, 64'h7fff_ffff, 64'd1, 1'b0, 8'hff);
    queue_instr(CMD_ADDQ,   '1, '0, 1'b1, 8'hff);
    queue_instr(CMD_ADDQ_V, {1'b0, {63{1'b1}}}, 64'd1, 1'b0, 8'h00);
    queue_instr(CMD_S4ADDL, 64'hc000_0000_4000_0000, 64'hffff_ffff, 1'b0, 8'h00);
    queue_instr(CMD_S8ADDL, '1, '1, 1'b1, 8'h00);
    queue_instr(CMD_S4ADDQ, 64'he000_0000_0000_0001, {1'b1, 63'd0}, 1'b0, 8'h00);
    queue_instr(CMD_S8ADDQ, 64'h2000_0000_0000_0000, '1, 1'b0, 8'h00);
    queue_instr(CMD_CMPEQ,  '1, '1, 1'b0, 8'h00);
    queue_instr(CMD_CMPLE,  {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 1'b0, 8'h00);
    queue_instr(CMD_CMPLT,  {1'b1, 63'd0}, {1'b1, 63'd0}, 1'b0, 8'h00);
    queue_instr(CMD_CMPULE, '1, '0, 1'b1, 8'hff);
    queue_instr(CMD_CTLZ,   '1, '0, 1'b0, 8'hff);
    queue_instr(CMD_CTTZ,   '1, '1, 1'b1, 8'h00);
    queue_instr(CMD_MULL,   64'h8000_0000, 64'hffff_ffff, 1'b0, 8'h00);
    queue_instr(CMD_MULL_V, 64'h8000_0000, 64'hffff_ffff, 1'b0, 8'h00);
    queue_instr(CMD_MULQ,   '1, '1, 1'b0, 8'h00);
    queue_instr(CMD_MULQ_V, {1'b1, 63'd0}, '1, 1'b0, 8'h00);
    queue_instr(CMD_UMULH,  '1, '1, 1'b0, 8'h00);
    queue_instr(CMD_SUBL,   '0, 64'd1, 1'b0, 8'h00);
    queue_instr(CMD_SUBL_V, 64'h8000_0000, 64'd1, 1'b0, 8'h00);
    queue_instr(CMD_SUBQ,   '0, '1, 1'b0, 8'h00);
    queue_instr(CMD_SUBQ_V, {1'b1, 63'd0}, 64'd1, 1'b0, 8'h00);
    queue_instr(CMD_S4SUBL, 64'h3fff_ffff, '0, 1'b1, 8'hff);
    queue_instr(CMD_S8SUBL, 64'h1000_0000, 64'h8000_0000, 1'b0, 8'h00);
    queue_instr(CMD_S4SUBQ, '0, {1'b1, 63'd0}, 1'b0, 8'h00);
    queue_instr(CMD_S8SUBQ, '1, 64'hffff_ffff_0000_0000, 1'b0, 8'h00);
    queue_instr(cmd_t'(2 ** $bits(cmd_t) - 1), '1, '1, 1'b1, 8'hff);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      idle_phase = ph;
      queue_random(RANDOM_PER_PHASE);
      while (instr_q.size() != 0) @(negedge clk);
    end
    while (in_valid || writeback_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
